@@ rtl/simplex_shape_function_eval_defines.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef SIMPLEX_SHAPE_FUNCTION_EVAL_DEFINES_SVH
`define SIMPLEX_SHAPE_FUNCTION_EVAL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ssfe: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ssfe: next-cycle check failed");

`endif

@@ rtl/ssfe_pkg.sv @@
`default_nettype none

package ssfe_pkg;

    localparam int COORD_W = 32;
    localparam int OUT_W   = 40;
    localparam int IDX_W   = 4;
    localparam int ORDER_W = 2;
    localparam int SRC_W   = 3;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 40'sh80_0000_0000;

    localparam logic [ORDER_W-1:0] ORDER_NONE   = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_LINEAR = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_QUAD   = 2'd2;

    localparam logic [SRC_W-1:0] SRC_L0   = 3'd0;
    localparam logic [SRC_W-1:0] SRC_L1   = 3'd1;
    localparam logic [SRC_W-1:0] SRC_L2   = 3'd2;
    localparam logic [SRC_W-1:0] SRC_L3   = 3'd3;
    localparam logic [SRC_W-1:0] SRC_HALF = 3'd4;
    localparam logic [SRC_W-1:0] SRC_ONE  = 3'd5;

    localparam logic [IDX_W-1:0] LAST_TRI_LIN  = 4'd2;
    localparam logic [IDX_W-1:0] LAST_TET_LIN  = 4'd3;
    localparam logic [IDX_W-1:0] LAST_TRI_QUAD = 4'd5;
    localparam logic [IDX_W-1:0] LAST_TET_QUAD = 4'd9;

    // A derivative term is 2*pos - 2*neg, each side optional.
    typedef struct packed {
        logic             pe;
        logic [SRC_W-1:0] p;
        logic             ne;
        logic [SRC_W-1:0] n;
    } t_term;

    typedef struct packed {
        logic [SRC_W-1:0] a;
        logic [SRC_W-1:0] b;
        logic             half_sh;
        t_term            dr;
        t_term            ds;
        t_term            dt;
        logic             last;
    } t_task;

    localparam t_term T_ZERO = '{pe: 1'b0, p: SRC_L0, ne: 1'b0, n: SRC_L0};

    function automatic t_term tp(logic [SRC_W-1:0] src);
        return '{pe: 1'b1, p: src, ne: 1'b0, n: SRC_L0};
    endfunction

    function automatic t_term tn(logic [SRC_W-1:0] src);
        return '{pe: 1'b0, p: SRC_L0, ne: 1'b1, n: src};
    endfunction

    function automatic t_term tpn(logic [SRC_W-1:0] ps, logic [SRC_W-1:0] ns);
        return '{pe: 1'b1, p: ps, ne: 1'b1, n: ns};
    endfunction

    function automatic t_task ent(logic [SRC_W-1:0] a, logic [SRC_W-1:0] b, logic half_sh,
                                  t_term dr, t_term ds, t_term dt, logic last);
        return '{a: a, b: b, half_sh: half_sh, dr: dr, ds: ds, dt: dt, last: last};
    endfunction

    // Linear functions use b = 1.0 so the product unit passes L through with saturation.
    function automatic t_task get_task(logic tet, logic quad, logic [IDX_W-1:0] k);
        t_task tk;
        tk = ent(SRC_L0, SRC_ONE, 1'b0, T_ZERO, T_ZERO, T_ZERO, 1'b1);
        case ({tet, quad})
            2'b11: begin
                case (k)
                    4'd0: tk = ent(SRC_L0, SRC_L0, 1'b0, tp(SRC_L0), T_ZERO, T_ZERO, 1'b0);
                    4'd1: tk = ent(SRC_L1, SRC_L1, 1'b0, T_ZERO, tp(SRC_L1), T_ZERO, 1'b0);
                    4'd2: tk = ent(SRC_L2, SRC_L2, 1'b0, T_ZERO, T_ZERO, tp(SRC_L2), 1'b0);
                    4'd3: tk = ent(SRC_L3, SRC_L3, 1'b0, tn(SRC_L3), tn(SRC_L3), tn(SRC_L3),
                                   1'b0);
                    4'd4: tk = ent(SRC_L0, SRC_L2, 1'b1, tp(SRC_L2), T_ZERO, tp(SRC_L0), 1'b0);
                    4'd5: tk = ent(SRC_L1, SRC_L2, 1'b1, T_ZERO, tp(SRC_L2), tp(SRC_L1), 1'b0);
                    4'd6: tk = ent(SRC_L0, SRC_L1, 1'b1, tp(SRC_L1), tp(SRC_L0), T_ZERO, 1'b0);
                    4'd7: tk = ent(SRC_L0, SRC_L3, 1'b1, tpn(SRC_L3, SRC_L0), tn(SRC_L0),
                                   tn(SRC_L0), 1'b0);
                    4'd8: tk = ent(SRC_L2, SRC_L3, 1'b1, tn(SRC_L2), tn(SRC_L2),
                                   tpn(SRC_L3, SRC_L2), 1'b0);
                    4'd9: tk = ent(SRC_L1, SRC_L3, 1'b1, tn(SRC_L1), tpn(SRC_L3, SRC_L1),
                                   tn(SRC_L1), 1'b1);
                    default: tk = ent(SRC_L0, SRC_ONE, 1'b0, T_ZERO, T_ZERO, T_ZERO, 1'b1);
                endcase
            end
            2'b10: begin
                case (k)
                    4'd0: tk = ent(SRC_L0, SRC_ONE, 1'b0, tp(SRC_HALF), T_ZERO, T_ZERO, 1'b0);
                    4'd1: tk = ent(SRC_L1, SRC_ONE, 1'b0, T_ZERO, tp(SRC_HALF), T_ZERO, 1'b0);
                    4'd2: tk = ent(SRC_L2, SRC_ONE, 1'b0, T_ZERO, T_ZERO, tp(SRC_HALF), 1'b0);
                    4'd3: tk = ent(SRC_L3, SRC_ONE, 1'b0, tn(SRC_HALF), tn(SRC_HALF),
                                   tn(SRC_HALF), 1'b1);
                    default: tk = ent(SRC_L0, SRC_ONE, 1'b0, T_ZERO, T_ZERO, T_ZERO, 1'b1);
                endcase
            end
            2'b01: begin
                case (k)
                    4'd0: tk = ent(SRC_L0, SRC_L0, 1'b0, tp(SRC_L0), T_ZERO, T_ZERO, 1'b0);
                    4'd1: tk = ent(SRC_L1, SRC_L1, 1'b0, T_ZERO, tp(SRC_L1), T_ZERO, 1'b0);
                    4'd2: tk = ent(SRC_L2, SRC_L2, 1'b0, tn(SRC_L2), tn(SRC_L2), T_ZERO, 1'b0);
                    4'd3: tk = ent(SRC_L0, SRC_L2, 1'b1, tpn(SRC_L2, SRC_L0), tn(SRC_L0),
                                   T_ZERO, 1'b0);
                    4'd4: tk = ent(SRC_L1, SRC_L2, 1'b1, tn(SRC_L1), tpn(SRC_L2, SRC_L1),
                                   T_ZERO, 1'b0);
                    4'd5: tk = ent(SRC_L0, SRC_L1, 1'b1, tp(SRC_L1), tp(SRC_L0), T_ZERO, 1'b1);
                    default: tk = ent(SRC_L0, SRC_ONE, 1'b0, T_ZERO, T_ZERO, T_ZERO, 1'b1);
                endcase
            end
            default: begin
                case (k)
                    4'd0: tk = ent(SRC_L0, SRC_ONE, 1'b0, tp(SRC_HALF), T_ZERO, T_ZERO, 1'b0);
                    4'd1: tk = ent(SRC_L1, SRC_ONE, 1'b0, T_ZERO, tp(SRC_HALF), T_ZERO, 1'b0);
                    4'd2: tk = ent(SRC_L2, SRC_ONE, 1'b0, tn(SRC_HALF), tn(SRC_HALF), T_ZERO,
                                   1'b1);
                    default: tk = ent(SRC_L0, SRC_ONE, 1'b0, T_ZERO, T_ZERO, T_ZERO, 1'b1);
                endcase
            end
        endcase
        return tk;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ssfe_mulq.sv @@
`default_nettype none

module ssfe_mulq #(
    parameter int FRAC_BITS = 30,
    parameter int LW        = 35
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [LW-1:0]               i_a,
    input  wire logic signed [LW-1:0]               i_b,
    input  wire logic                               i_half_sh,
    output logic signed [ssfe_pkg::OUT_W-1:0]       o_value
);
    import ssfe_pkg::*;

    localparam int MW = LW - 1;
    localparam int HW = MW - 32;
    localparam int RW = 2 * MW + 1;

    localparam logic [RW-1:0] RND_FULL = RW'(1) << (FRAC_BITS - 1);
    localparam logic [RW-1:0] RND_HALF = RW'(1) << (FRAC_BITS - 2);
    localparam logic [RW-1:0] MAG_MAX  = RW'(OUT_MAX);
    localparam logic [RW-1:0] MAG_NEG  = RW'(OUT_MAX) + RW'(1);

    logic          r_q1_neg, r_q2_neg, r_q3_neg;
    logic          r_q1_half, r_q2_half, r_q3_half;
    logic [MW-1:0] r_ma, r_mb;
    logic [63:0]   r_ll;
    logic [31+HW:0] r_lh, r_hl;
    logic [2*HW-1:0] r_hh;
    logic [RW-1:0] r_p;
    logic [LW-1:0] abs_a, abs_b;
    logic [RW-1:0] mag;

    assign abs_a = i_a[LW-1] ? LW'(-i_a) : LW'(i_a);
    assign abs_b = i_b[LW-1] ? LW'(-i_b) : LW'(i_b);
    assign mag   = r_q3_half ? (r_p >> (FRAC_BITS - 1)) : (r_p >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q1_neg  <= i_a[LW-1] ^ i_b[LW-1];
            r_q1_half <= i_half_sh;
            r_ma      <= abs_a[MW-1:0];
            r_mb      <= abs_b[MW-1:0];

            r_q2_neg  <= r_q1_neg;
            r_q2_half <= r_q1_half;
            r_ll      <= r_ma[31:0] * r_mb[31:0];
            r_lh      <= r_ma[31:0] * r_mb[MW-1:32];
            r_hl      <= r_ma[MW-1:32] * r_mb[31:0];
            r_hh      <= r_ma[MW-1:32] * r_mb[MW-1:32];

            r_q3_neg  <= r_q2_neg;
            r_q3_half <= r_q2_half;
            r_p       <= RW'(r_ll) + (RW'(r_lh) << 32) + (RW'(r_hl) << 32)
                         + (RW'(r_hh) << 64) + (r_q2_half ? RND_HALF : RND_FULL);

            if (r_q3_neg) begin
                o_value <= (mag >= MAG_NEG) ? OUT_MIN : OUT_W'(-mag);
            end else begin
                o_value <= (mag > MAG_MAX) ? OUT_MAX : OUT_W'(mag);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/simplex_shape_function_eval.sv @@
// Shape functions on a triangle or tetrahedron at one parametric point.
// Input channel: i_in_valid / o_in_stall with is_tet and Q2.30 coordinates r, s, t.
// Output channel: o_res_valid / i_res_stall, one shape function per item with its
// index, value, three derivatives and a last flag on the final one of the point.
// Configuration: i_cfg_valid / o_cfg_ready (always ready) writes poly_order;
// write it only while the block is idle. Order 0 drops points without output.
// Each point expands to 3, 4, 6 or 10 result items at one item per cycle while the
// receiver does not stall, so the result sequencer limits how often a new point is
// taken. A point is accepted in the cycle the sequencer issues the previous point's
// last item. From acceptance to the first result a point passes a six-register
// pipeline (sequencer, operand select, magnitude, partial products, sum, round).
// Reset (synchronous, active low) empties the pipeline and sets poly_order to 2.
// When the receiver stalls with a result waiting, the whole pipeline holds and the
// input is stalled with it; no item is lost or repeated.
`default_nettype none
`include "simplex_shape_function_eval_defines.svh"

module simplex_shape_function_eval #(
    parameter int COORD_FRAC_BITS = 30
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ssfe_pkg::ORDER_W-1:0]          i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic                                  i_is_tet,
    input  wire logic signed [ssfe_pkg::COORD_W-1:0]   i_coord_r,
    input  wire logic signed [ssfe_pkg::COORD_W-1:0]   i_coord_s,
    input  wire logic signed [ssfe_pkg::COORD_W-1:0]   i_coord_t,
    output logic                                       o_res_valid,
    input  wire logic                                  i_res_stall,
    output logic [ssfe_pkg::IDX_W-1:0]                 o_shape_index,
    output logic signed [ssfe_pkg::OUT_W-1:0]          o_shape_value,
    output logic signed [ssfe_pkg::OUT_W-1:0]          o_deriv_r,
    output logic signed [ssfe_pkg::OUT_W-1:0]          o_deriv_s,
    output logic signed [ssfe_pkg::OUT_W-1:0]          o_deriv_t,
    output logic                                       o_last
);
    import ssfe_pkg::*;

    localparam int MB = (COORD_FRAC_BITS > 32) ? COORD_FRAC_BITS : 32;
    localparam int LW = MB + 3;
    localparam int DW = LW + 2;
    localparam int EW = (DW > 41) ? DW : 41;

    localparam logic signed [LW-1:0] ONE_V  = LW'(1) << COORD_FRAC_BITS;
    localparam logic signed [LW-1:0] HALF_V = LW'(1) << (COORD_FRAC_BITS - 1);
    localparam logic signed [EW-1:0] SAT_HI = EW'(OUT_MAX);
    localparam logic signed [EW-1:0] SAT_LO = EW'(OUT_MIN);

    function automatic logic signed [OUT_W-1:0] sat_d(logic signed [DW-1:0] v);
        logic signed [EW-1:0] x;
        x = EW'(v);
        if (x > SAT_HI) begin
            return OUT_MAX;
        end
        if (x < SAT_LO) begin
            return OUT_MIN;
        end
        return x[OUT_W-1:0];
    endfunction

    logic [ORDER_W-1:0] r_order;

    logic              r_seq_valid;
    logic              r_seq_tet;
    logic              r_seq_quad;
    logic [IDX_W-1:0]  r_seq_k;
    logic signed [LW-1:0] r_l [4];

    logic signed [LW-1:0] n_r, n_s, n_t, n_l2, n_l3;
    t_task             tk;
    logic              pipe_en;
    logic              seq_free;
    logic              in_acc;

    logic              r1_valid, r2_valid, r3_valid, r4_valid, r_out_valid;
    logic signed [LW-1:0] r1_a, r1_b;
    logic              r1_half;
    logic signed [LW-1:0] r1_dp [3];
    logic signed [LW-1:0] r1_dn [3];
    logic signed [DW-1:0] r2_d [3];
    logic signed [OUT_W-1:0] r3_d [3];
    logic signed [OUT_W-1:0] r4_d [3];
    logic signed [OUT_W-1:0] r_out_d [3];
    logic [IDX_W-1:0]  r1_idx, r2_idx, r3_idx, r4_idx, r_out_idx;
    logic              r1_last, r2_last, r3_last, r4_last, r_out_last;
    t_term             terms [3];

    function automatic logic signed [LW-1:0] sel_src(logic [SRC_W-1:0] code,
                                                     logic signed [LW-1:0] l0,
                                                     logic signed [LW-1:0] l1,
                                                     logic signed [LW-1:0] l2,
                                                     logic signed [LW-1:0] l3);
        case (code)
            SRC_L0:   return l0;
            SRC_L1:   return l1;
            SRC_L2:   return l2;
            SRC_L3:   return l3;
            SRC_HALF: return HALF_V;
            SRC_ONE:  return ONE_V;
            default:  return '0;
        endcase
    endfunction

    assign o_cfg_ready = 1'b1;

    assign n_r  = LW'(i_coord_r);
    assign n_s  = LW'(i_coord_s);
    assign n_t  = LW'(i_coord_t);
    assign n_l3 = ONE_V - n_r - n_s - n_t;
    assign n_l2 = i_is_tet ? n_t : (ONE_V - n_r - n_s);

    assign tk       = get_task(r_seq_tet, r_seq_quad, r_seq_k);
    assign pipe_en  = !r_out_valid || !i_res_stall;
    assign seq_free = !r_seq_valid || tk.last;
    assign o_in_stall = !(pipe_en && seq_free);
    assign in_acc   = i_in_valid && !o_in_stall;

    assign terms[0] = tk.dr;
    assign terms[1] = tk.ds;
    assign terms[2] = tk.dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_QUAD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_order <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_valid <= 1'b0;
            r_seq_k     <= '0;
        end else if (pipe_en) begin
            if (seq_free) begin
                r_seq_valid <= in_acc && (r_order != ORDER_NONE);
                r_seq_k     <= '0;
            end else begin
                r_seq_k     <= r_seq_k + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_seq_tet  <= i_is_tet;
            r_seq_quad <= r_order[1];
            r_l[0]     <= n_r;
            r_l[1]     <= n_s;
            r_l[2]     <= n_l2;
            r_l[3]     <= n_l3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r1_valid    <= r_seq_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r_out_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_a    <= sel_src(tk.a, r_l[0], r_l[1], r_l[2], r_l[3]);
            r1_b    <= sel_src(tk.b, r_l[0], r_l[1], r_l[2], r_l[3]);
            r1_half <= tk.half_sh;
            r1_idx  <= r_seq_k;
            r1_last <= tk.last;
            for (int i = 0; i < 3; i++) begin
                r1_dp[i] <= terms[i].pe ?
                            sel_src(terms[i].p, r_l[0], r_l[1], r_l[2], r_l[3]) : '0;
                r1_dn[i] <= terms[i].ne ?
                            sel_src(terms[i].n, r_l[0], r_l[1], r_l[2], r_l[3]) : '0;
                r2_d[i]    <= (DW'(r1_dp[i]) <<< 1) - (DW'(r1_dn[i]) <<< 1);
                r3_d[i]    <= sat_d(r2_d[i]);
                r4_d[i]    <= r3_d[i];
                r_out_d[i] <= r4_d[i];
            end
            r2_idx     <= r1_idx;
            r3_idx     <= r2_idx;
            r4_idx     <= r3_idx;
            r_out_idx  <= r4_idx;
            r2_last    <= r1_last;
            r3_last    <= r2_last;
            r4_last    <= r3_last;
            r_out_last <= r4_last;
        end
    end

    ssfe_mulq #(
        .FRAC_BITS (COORD_FRAC_BITS),
        .LW        (LW)
    ) u_mulq (
        .i_clk     (i_clk),
        .i_en      (pipe_en),
        .i_a       (r1_a),
        .i_b       (r1_b),
        .i_half_sh (r1_half),
        .o_value   (o_shape_value)
    );

    assign o_res_valid   = r_out_valid;
    assign o_shape_index = r_out_idx;
    assign o_deriv_r     = r_out_d[0];
    assign o_deriv_s     = r_out_d[1];
    assign o_deriv_t     = r_out_d[2];
    assign o_last        = r_out_last;

    `SSFE_ASSERT_SAME(a_index_range, i_clk, i_rst_n, o_res_valid,
                      o_shape_index <= LAST_TET_QUAD)
    `SSFE_ASSERT_SAME(a_last_index, i_clk, i_rst_n, o_res_valid && o_last,
                      o_shape_index == LAST_TRI_LIN || o_shape_index == LAST_TET_LIN ||
                      o_shape_index == LAST_TRI_QUAD || o_shape_index == LAST_TET_QUAD)
    `SSFE_ASSERT_NEXT(a_seq_advance, i_clk, i_rst_n, r_seq_valid && !tk.last && pipe_en,
                      r_seq_valid && r_seq_k == $past(r_seq_k) + IDX_W'(1))

endmodule

`default_nettype wire
